// ===== rtl/cpu8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_pkg
// Command codes, flag positions and field widths of the 8-bit ALU
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    localparam int unsigned CMD_W   = 5;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIDX_W  = 3;
    localparam int unsigned FLAG_W  = 4;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [FLAG_W-1:0] FLAGS_RESET = 4'b1011;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 5'd0,
        CMD_ADC        = 5'd1,
        CMD_SUB        = 5'd2,
        CMD_SBC        = 5'd3,
        CMD_AND        = 5'd4,
        CMD_OR         = 5'd5,
        CMD_XOR        = 5'd6,
        CMD_RLC        = 5'd7,
        CMD_RL         = 5'd8,
        CMD_RRC        = 5'd9,
        CMD_RR         = 5'd10,
        CMD_BIT        = 5'd11,
        CMD_RES        = 5'd12,
        CMD_SET        = 5'd13,
        CMD_SWAP       = 5'd14,
        CMD_INC8       = 5'd15,
        CMD_DEC8       = 5'd16,
        CMD_INC16      = 5'd17,
        CMD_DEC16      = 5'd18,
        CMD_ADD16      = 5'd19,
        CMD_ADD_SP_E8  = 5'd20,
        CMD_LOAD_FLAGS = 5'd21
    } t_cmd;

endpackage

// ===== rtl/cpu8_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags
// 8-bit CPU ALU with zero, subtract, half-carry and carry flags
// ----------------------------------------------------------------------------
// One request goes in per cycle while the output keeps taking results: it lands
// in an input register, the whole operation is done in one combinational pass
// against the stored flags, and the result with its new flags lands in the
// output register. The stored flags are updated as each request moves into
// the output register, so carry chains correctly between back-to-back
// requests. A stalled output holds the input register as a skid stage; the
// input side stops only when both are full.
// Flags come out of reset as zero, half-carry and carry set.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags
    import cpu8alu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] operand_a, [31:16] operand_b, [34:32] bit_index, [39:35] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // [4:0] cmd
    input  logic [CMD_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [15:0] result, [19:16] flags_out, [23:20] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    // input stage
    logic                r_in_vld;
    logic [CMD_W-1:0]    r_cmd;
    logic [WORD_W-1:0]   r_opa;
    logic [WORD_W-1:0]   r_opb;
    logic [BIDX_W-1:0]   r_bidx;

    // output stage and flag state
    logic                r_out_vld;
    logic [WORD_W-1:0]   r_result;
    logic [FLAG_W-1:0]   r_flags_out;
    logic [FLAG_W-1:0]   r_flags;

    logic                w_s_acc;
    logic                w_out_free;
    logic                w_adv;

    logic [WORD_W-1:0]   n_result;
    logic [FLAG_W-1:0]   n_flags;

    // datapath helpers
    logic [BYTE_W-1:0]   w_a;
    logic [BYTE_W-1:0]   w_b;
    logic                w_cin;
    logic                w_cin_sel;
    logic [BYTE_W:0]     w_add9;
    logic [4:0]          w_add_h;
    logic [BYTE_W:0]     w_sub9;
    logic [BYTE_W:0]     w_bc9;
    logic [4:0]          w_bc_h;
    logic [WORD_W:0]     w_add17;
    logic [12:0]         w_add13;
    logic [BYTE_W-1:0]   w_mask;
    logic [BYTE_W-1:0]   w_hi;
    logic [BYTE_W-1:0]   w_r8;
    logic                w_out_bit;

    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_s_tready = !r_in_vld || w_out_free;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0000, r_flags_out, r_result};

    assign w_a   = r_opa[BYTE_W-1:0];
    assign w_b   = r_opb[BYTE_W-1:0];
    assign w_cin = r_flags[FLAG_C];

    // adder and subtractor carry in only for adc and sbc
    assign w_cin_sel = ((r_cmd == CMD_ADC) || (r_cmd == CMD_SBC)) ? w_cin : 1'b0;

    assign w_add9  = {1'b0, w_a} + {1'b0, w_b} + {{BYTE_W{1'b0}}, w_cin_sel};
    assign w_add_h = {1'b0, w_a[3:0]} + {1'b0, w_b[3:0]} + {4'b0000, w_cin_sel};
    assign w_sub9  = {1'b0, w_a} - {1'b0, w_b} - {{BYTE_W{1'b0}}, w_cin_sel};
    assign w_bc9   = {1'b0, w_b} + {{BYTE_W{1'b0}}, w_cin_sel};
    assign w_bc_h  = {1'b0, w_b[3:0]} + {4'b0000, w_cin_sel};
    assign w_add17 = {1'b0, r_opa} + {1'b0, r_opb};
    assign w_add13 = {1'b0, r_opa[11:0]} + {1'b0, r_opb[11:0]};
    assign w_mask  = BYTE_W'(1) << r_bidx;

    always_comb begin
        n_result  = '0;
        n_flags   = r_flags;
        w_r8      = '0;
        w_out_bit = 1'b0;
        w_hi      = r_opa[WORD_W-1:BYTE_W];
        case (r_cmd)
            CMD_ADD, CMD_ADC: begin
                n_result         = {8'h00, w_add9[BYTE_W-1:0]};
                n_flags[FLAG_Z]  = (w_add9[BYTE_W-1:0] == '0);
                n_flags[FLAG_N]  = 1'b0;
                n_flags[FLAG_H]  = w_add_h[4];
                n_flags[FLAG_C]  = w_add9[BYTE_W];
            end
            CMD_SUB, CMD_SBC: begin
                n_result         = {8'h00, w_sub9[BYTE_W-1:0]};
                n_flags[FLAG_Z]  = (w_sub9[BYTE_W-1:0] == '0);
                n_flags[FLAG_N]  = 1'b1;
                n_flags[FLAG_H]  = ({1'b0, w_a[3:0]} < w_bc_h);
                n_flags[FLAG_C]  = ({1'b0, w_a} < w_bc9);
            end
            CMD_AND: begin
                w_r8     = w_a & w_b;
                n_result = {8'h00, w_r8};
                n_flags  = {(w_r8 == '0), 1'b0, 1'b1, 1'b0};
            end
            CMD_OR: begin
                w_r8     = w_a | w_b;
                n_result = {8'h00, w_r8};
                n_flags  = {(w_r8 == '0), 3'b000};
            end
            CMD_XOR: begin
                w_r8     = w_a ^ w_b;
                n_result = {8'h00, w_r8};
                n_flags  = {(w_r8 == '0), 3'b000};
            end
            CMD_RLC, CMD_RL: begin
                w_out_bit = w_a[7];
                w_r8      = {w_a[6:0], (r_cmd == CMD_RLC) ? w_out_bit : w_cin};
                n_result  = {8'h00, w_r8};
                n_flags   = {(w_r8 == '0), 2'b00, w_out_bit};
            end
            CMD_RRC, CMD_RR: begin
                w_out_bit = w_a[0];
                w_r8      = {(r_cmd == CMD_RRC) ? w_out_bit : w_cin, w_a[7:1]};
                n_result  = {8'h00, w_r8};
                n_flags   = {(w_r8 == '0), 2'b00, w_out_bit};
            end
            CMD_BIT: begin
                n_result        = {8'h00, w_a};
                n_flags[FLAG_Z] = !w_a[r_bidx];
                n_flags[FLAG_N] = 1'b0;
                n_flags[FLAG_H] = 1'b1;
            end
            CMD_RES: begin
                n_result = {8'h00, w_a & ~w_mask};
            end
            CMD_SET: begin
                n_result = {8'h00, w_a | w_mask};
            end
            CMD_SWAP: begin
                w_r8     = {w_a[3:0], w_a[7:4]};
                n_result = {8'h00, w_r8};
                n_flags  = {(w_r8 == '0), 3'b000};
            end
            CMD_INC8: begin
                w_r8            = w_a + 8'd1;
                n_result        = {8'h00, w_r8};
                n_flags[FLAG_Z] = (w_r8 == '0);
                n_flags[FLAG_N] = 1'b0;
                n_flags[FLAG_H] = (w_r8[3:0] == 4'h0);
            end
            CMD_DEC8: begin
                w_r8            = w_a - 8'd1;
                n_result        = {8'h00, w_r8};
                n_flags[FLAG_Z] = (w_r8 == '0);
                n_flags[FLAG_N] = 1'b1;
                n_flags[FLAG_H] = (w_r8[3:0] == 4'hF);
            end
            CMD_INC16: begin
                n_result = r_opa + 16'd1;
            end
            CMD_DEC16: begin
                n_result = r_opa - 16'd1;
            end
            CMD_ADD16: begin
                n_result        = w_add17[WORD_W-1:0];
                n_flags[FLAG_N] = 1'b0;
                n_flags[FLAG_H] = w_add13[12];
                n_flags[FLAG_C] = w_add17[WORD_W];
            end
            CMD_ADD_SP_E8: begin
                // high byte follows the sign of e8 against the low-byte carry
                if (w_add9[BYTE_W] && !w_b[7]) begin
                    w_hi = r_opa[WORD_W-1:BYTE_W] + 8'd1;
                end else if (!w_add9[BYTE_W] && w_b[7]) begin
                    w_hi = r_opa[WORD_W-1:BYTE_W] - 8'd1;
                end
                n_result = {w_hi, w_add9[BYTE_W-1:0]};
                n_flags  = {1'b0, 1'b0, w_add_h[4], w_add9[BYTE_W]};
            end
            CMD_LOAD_FLAGS: begin
                n_flags  = w_a[7:4];
                n_result = {8'h00, w_a[7:4], 4'h0};
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= FLAGS_RESET;
        end else begin
            if (w_s_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_flags;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_cmd  <= i_s_tuser;
            r_opa  <= i_s_tdata[15:0];
            r_opb  <= i_s_tdata[31:16];
            r_bidx <= i_s_tdata[34:32];
        end
        if (w_adv) begin
            r_result    <= n_result;
            r_flags_out <= n_flags;
        end
    end

endmodule

// ===== rtl/cpu8alu_checker.sv =====
// ----------------------------------------------------------------------------
// cpu8alu_checker
// Port-level checks for the 8-bit ALU stream interface
// ----------------------------------------------------------------------------
module cpu8alu_checker
    import cpu8alu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  o_m_tdata
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // an accepted request must find the output valid once it has passed the input and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> ##2 o_m_tvalid)
        else $error("request did not reach the output");

    // input backs up only behind a stalled output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind cpu8_alu_with_flags cpu8alu_checker u_cpu8alu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
